// ===== rtl/core/srarq_pkg.sv =====
// shared types, codes and defaults of the selective-repeat sender
package srarq_pkg;

  localparam int MAX_PACKETS_DEF = 16;
  localparam int MAX_WINDOW_DEF  = 8;
  localparam int RESULT_CAP      = 8;

  localparam logic [4:0] PACKET_TOTAL_RST  = 5'd10;
  localparam logic [3:0] WINDOW_WIDTH_RST  = 4'd3;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd5;

  localparam logic [1:0] CFG_PACKET_TOTAL  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_NACK    = 2'd2,
    MODE_INVALID = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_FIRST   = 3'd0,
    KIND_TIMEOUT = 3'd1,
    KIND_NACK    = 3'd2,
    KIND_INVALID = 3'd3,
    KIND_BAD_ID  = 3'd4,
    KIND_DONE    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_TICK   = 2'd1,
    WR_NACK   = 2'd2,
    WR_LAUNCH = 2'd3
  } wr_src_t;

  typedef struct packed {
    logic    load_in;
    logic    scan_init;
    logic    scan_inc;
    logic    tmr_rd;
    wr_src_t tmr_wr;
    logic    ack_set;
    logic    base_inc;
    logic    unsent_inc;
    logic    done_set;
    logic    emit;
    kind_t   emit_kind;
    logic    flush;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  bad_id;
    logic  done;
    logic  ack_live;
    logic  nack_live;
    logic  scan_more;
    logic  tick_live;
    logic  tick_expire;
    logic  slide_more;
    logic  launch_more;
    logic  finish;
    logic  pend_valid;
    logic  push_ok;
  } sts_t;

endpackage

// ===== rtl/core/srarq_dp.sv =====
// datapath: window state, retry timer memory, result staging and output register
module srarq_dp #(
  parameter int MAX_PACKETS = srarq_pkg::MAX_PACKETS_DEF,
  parameter int MAX_WINDOW  = srarq_pkg::MAX_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [7:0]        cfg_wdata,
  input  logic [7:0]        in_tdata,
  input  logic [1:0]        in_tuser,
  input  srarq_pkg::cmd_t   cmd,
  output srarq_pkg::sts_t   sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  localparam int CNTW = $clog2(MAX_PACKETS + 1);
  localparam int IDXW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int WINW = $clog2(MAX_WINDOW + 1);
  localparam int CAPW = $clog2(srarq_pkg::RESULT_CAP + 1);

  logic [4:0]             packet_total_r;
  logic [3:0]             window_width_r;
  logic [7:0]             timeout_ticks_r;
  srarq_pkg::mode_t       mode_r;
  logic [4:0]             id_r;
  logic [CNTW-1:0]        base_r;
  logic [CNTW-1:0]        unsent_r;
  logic [CNTW-1:0]        idx_r;
  logic [MAX_PACKETS-1:0] acked_r;
  logic                   done_r;
  logic [CAPW-1:0]        cnt_r;
  logic [7:0]             tmr_mem [MAX_PACKETS];
  logic [7:0]             tmr_rdata_r;
  logic                   pend_valid_r;
  srarq_pkg::kind_t       pend_kind_r;
  logic [4:0]             pend_id_r;
  logic                   out_valid_r;
  logic [2:0]             out_kind_r;
  logic [4:0]             out_id_r;
  logic                   out_last_r;

  logic [CNTW-1:0] total_eff;
  logic [WINW-1:0] win_eff;
  logic [7:0]      tmo_eff;
  logic [CNTW-1:0] in_flight;
  logic [IDXW-1:0] id_k;
  logic            under_cap;
  logic            out_free;
  logic            emit_go;
  logic [4:0]      emit_id;
  logic            tmr_we;
  logic [IDXW-1:0] tmr_waddr;
  logic [7:0]      tmr_wdata;

  // clamped register values
  always_comb begin
    if (packet_total_r == '0) begin
      total_eff = CNTW'(1);
    end else if (32'(packet_total_r) > 32'(MAX_PACKETS)) begin
      total_eff = CNTW'(MAX_PACKETS);
    end else begin
      total_eff = CNTW'(packet_total_r);
    end
    if (window_width_r == '0) begin
      win_eff = WINW'(1);
    end else if (32'(window_width_r) > 32'(MAX_WINDOW)) begin
      win_eff = WINW'(MAX_WINDOW);
    end else begin
      win_eff = WINW'(window_width_r);
    end
    tmo_eff = (timeout_ticks_r == '0) ? 8'd1 : timeout_ticks_r;
  end

  assign in_flight = unsent_r - base_r;
  assign id_k      = IDXW'(id_r - 5'd1);
  assign under_cap = cnt_r < CAPW'(srarq_pkg::RESULT_CAP);
  assign out_free  = !out_valid_r || out_tready;
  assign emit_go   = cmd.emit && under_cap;

  always_comb begin
    sts.mode        = mode_r;
    sts.bad_id      = (id_r == '0) || (32'(id_r) > 32'(total_eff));
    sts.done        = done_r;
    sts.ack_live    = 32'(id_r) <= 32'(unsent_r);
    sts.nack_live   = (32'(id_r) <= 32'(unsent_r)) && !acked_r[id_k];
    sts.scan_more   = idx_r < unsent_r;
    sts.tick_live   = !acked_r[IDXW'(idx_r)];
    sts.tick_expire = tmr_rdata_r <= 8'd1;
    sts.slide_more  = (base_r < total_eff) && acked_r[IDXW'(base_r)];
    sts.launch_more = under_cap && (32'(in_flight) < 32'(win_eff)) && (unsent_r < total_eff);
    sts.finish      = (base_r >= total_eff) && under_cap;
    sts.pend_valid  = pend_valid_r;
    sts.push_ok     = !pend_valid_r || out_free;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_total_r  <= srarq_pkg::PACKET_TOTAL_RST;
      window_width_r  <= srarq_pkg::WINDOW_WIDTH_RST;
      timeout_ticks_r <= srarq_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        srarq_pkg::CFG_PACKET_TOTAL:  packet_total_r  <= cfg_wdata[4:0];
        srarq_pkg::CFG_WINDOW_WIDTH:  window_width_r  <= cfg_wdata[3:0];
        srarq_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // latched request
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= srarq_pkg::mode_t'(in_tuser);
      id_r   <= in_tdata[4:0];
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      unsent_r <= '0;
      idx_r    <= '0;
      acked_r  <= '0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (cmd.scan_init) begin
        idx_r <= base_r;
      end else if (cmd.scan_inc) begin
        idx_r <= idx_r + CNTW'(1);
      end
      if (cmd.base_inc) begin
        base_r <= base_r + CNTW'(1);
      end
      if (cmd.unsent_inc) begin
        unsent_r <= unsent_r + CNTW'(1);
      end
      if (cmd.ack_set) begin
        acked_r[id_k] <= 1'b1;
      end
      if (cmd.done_set) begin
        done_r <= 1'b1;
      end
      if (cmd.load_in) begin
        cnt_r <= '0;
      end else if (emit_go) begin
        cnt_r <= cnt_r + CAPW'(1);
      end
    end
  end

  // retry timer memory
  always_comb begin
    tmr_we = cmd.tmr_wr != srarq_pkg::WR_NONE;
    case (cmd.tmr_wr)
      srarq_pkg::WR_TICK: begin
        tmr_waddr = IDXW'(idx_r);
        tmr_wdata = (tmr_rdata_r <= 8'd1) ? tmo_eff : tmr_rdata_r - 8'd1;
      end
      srarq_pkg::WR_NACK: begin
        tmr_waddr = id_k;
        tmr_wdata = tmo_eff;
      end
      srarq_pkg::WR_LAUNCH: begin
        tmr_waddr = IDXW'(unsent_r);
        tmr_wdata = tmo_eff;
      end
      default: begin
        tmr_waddr = '0;
        tmr_wdata = tmo_eff;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tmr_we) begin
      tmr_mem[tmr_waddr] <= tmr_wdata;
    end
    if (cmd.tmr_rd) begin
      tmr_rdata_r <= tmr_mem[IDXW'(idx_r)];
    end
  end

  // result staging: one held result so the final one can carry last
  always_comb begin
    case (cmd.emit_kind) inside
      srarq_pkg::KIND_FIRST:   emit_id = 5'(32'(unsent_r) + 32'd1);
      srarq_pkg::KIND_TIMEOUT: emit_id = 5'(32'(idx_r) + 32'd1);
      srarq_pkg::KIND_NACK,
      srarq_pkg::KIND_BAD_ID:  emit_id = id_r;
      default:                 emit_id = 5'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit_go) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (pend_valid_r && (emit_go || cmd.flush)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      pend_kind_r <= cmd.emit_kind;
      pend_id_r   <= emit_id;
    end
    if (pend_valid_r && (emit_go || cmd.flush)) begin
      out_kind_r <= pend_kind_r;
      out_id_r   <= pend_id_r;
      out_last_r <= cmd.flush && !emit_go;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_id_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(srarq_pkg::RESULT_CAP))
    else $error("result count above cap");

  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    unsent_r >= base_r)
    else $error("window base passed next unsent");

  a_unsent_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(unsent_r) <= 32'(MAX_PACKETS))
    else $error("next unsent out of range");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && pend_valid_r) |-> out_free)
    else $error("held result pushed into a full output register");
`endif

endmodule

// ===== rtl/core/srarq_ctrl.sv =====
// controller: sequences dispatch, timer scan, window slide, first sends and flush
module srarq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  srarq_pkg::sts_t sts,
  output srarq_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DISPATCH = 7'b0000010,
    ST_TICK_RD  = 7'b0000100,
    ST_TICK_WR  = 7'b0001000,
    ST_SLIDE    = 7'b0010000,
    ST_LAUNCH   = 7'b0100000,
    ST_FLUSH    = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = state_r == ST_IDLE;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.tmr_wr    = srarq_pkg::WR_NONE;
    cmd.emit_kind = srarq_pkg::KIND_FIRST;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.mode == srarq_pkg::MODE_INVALID) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = srarq_pkg::KIND_INVALID;
          state_nxt     = ST_FLUSH;
        end else if (sts.mode != srarq_pkg::MODE_TICK && sts.bad_id) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = srarq_pkg::KIND_BAD_ID;
          state_nxt     = ST_FLUSH;
        end else if (sts.done) begin
          state_nxt = ST_FLUSH;
        end else if (sts.mode == srarq_pkg::MODE_TICK) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_TICK_RD;
        end else if (sts.mode == srarq_pkg::MODE_NACK) begin
          if (sts.nack_live) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = srarq_pkg::KIND_NACK;
            cmd.tmr_wr    = srarq_pkg::WR_NACK;
          end
          state_nxt = ST_LAUNCH;
        end else if (sts.ack_live) begin
          cmd.ack_set = 1'b1;
          state_nxt   = ST_SLIDE;
        end else begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_TICK_RD: begin
        if (sts.scan_more) begin
          cmd.tmr_rd = 1'b1;
          state_nxt  = ST_TICK_WR;
        end else begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_TICK_WR: begin
        if (sts.push_ok) begin
          if (sts.tick_live) begin
            cmd.tmr_wr = srarq_pkg::WR_TICK;
            if (sts.tick_expire) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = srarq_pkg::KIND_TIMEOUT;
            end
          end
          cmd.scan_inc = 1'b1;
          state_nxt    = ST_TICK_RD;
        end
      end
      ST_SLIDE: begin
        if (sts.slide_more) begin
          cmd.base_inc = 1'b1;
        end else begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (sts.push_ok) begin
          if (sts.launch_more) begin
            cmd.tmr_wr     = srarq_pkg::WR_LAUNCH;
            cmd.emit       = 1'b1;
            cmd.emit_kind  = srarq_pkg::KIND_FIRST;
            cmd.unsent_inc = 1'b1;
          end else begin
            if (sts.finish) begin
              cmd.done_set  = 1'b1;
              cmd.emit      = 1'b1;
              cmd.emit_kind = srarq_pkg::KIND_DONE;
            end
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.push_ok) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DISPATCH))
    else $error("accepted request not dispatched");

  a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (state_r == ST_IDLE))
    else $error("flush did not end the request");
`endif

endmodule

// ===== rtl/core/selective_repeat_arq_sender_unit.sv =====
// top level: selective-repeat sender window, controller plus datapath
// an invalid or bad id result is staged, then loaded into the output register
// per request: latch and dispatch; then a scan of the outstanding packets on a tick, a
//   window slide on an ack of a sent packet, and first sends on a tick, ack or nack
//   before done; then a flush of the held result; a stalled output holds the request
// flow: one request at a time; each tick slot takes a timer read and a timer write step
// reset: rst_n synchronous active low; registers return to 10 / 3 / 5, window empty
module selective_repeat_arq_sender_unit #(
  parameter int MAX_PACKETS = srarq_pkg::MAX_PACKETS_DEF,
  parameter int MAX_WINDOW  = srarq_pkg::MAX_WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // packet_id [4:0], zero fill [7:5]
  input  logic [1:0] in_tuser,   // mode [1:0]
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // packet_id_out [4:0], zero fill [7:5]
  output logic [2:0] out_tuser,  // kind [2:0]
  output logic       out_tlast
);

  srarq_pkg::cmd_t cmd;
  srarq_pkg::sts_t sts;

  srarq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srarq_dp #(
    .MAX_PACKETS (MAX_PACKETS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sim/tb_top.sv =====
// testbench for the selective-repeat sender unit: directed table, then random phases
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_PKT    = srarq_pkg::MAX_PACKETS_DEF;
  localparam int MAX_WIN    = srarq_pkg::MAX_WINDOW_DEF;
  localparam int IDLE_HOLD  = 80;
  localparam int DRAIN_MAX  = 20000;
  localparam int N_PHASE    = 7;
  localparam int DIR_N      = 23;

  localparam int RX_OPEN    = 0;
  localparam int RX_COIN    = 1;
  localparam int RX_SPARSE  = 2;
  localparam int RX_CADENCE = 3;

  typedef struct packed {
    srarq_pkg::kind_t kind;
    logic [4:0]       pid;
    logic             last;
  } sr_result_t;

  typedef struct packed {
    srarq_pkg::mode_t m;
    logic [4:0]       id;
    logic             typed;
    srarq_pkg::kind_t k;
    logic [4:0]       kid;
  } dir_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  // window state mirrored by the predictor
  logic [4:0]  reg_total = srarq_pkg::PACKET_TOTAL_RST;
  logic [3:0]  reg_window = srarq_pkg::WINDOW_WIDTH_RST;
  logic [7:0]  reg_timeout = srarq_pkg::TIMEOUT_TICKS_RST;
  bit          pkt_acked [MAX_PKT];
  bit          pkt_launched [MAX_PKT];
  int unsigned pkt_timer [MAX_PKT];
  int unsigned base_idx = 0;
  int unsigned unsent_idx = 0;
  bit          xfer_done = 1'b0;

  sr_result_t  step_cmds [$];
  sr_result_t  due_cmds [$];
  int          err_cnt = 0;
  int          burst_left = 0;
  int          acks_granted = 0;

  int          rx_mode = RX_OPEN;
  int          rx_left = 0;
  int unsigned cyc = 0;

  dir_req_t dir_tab [DIR_N] = '{
    '{srarq_pkg::MODE_INVALID, 5'd0,  1'b1, srarq_pkg::KIND_INVALID, 5'd0},
    '{srarq_pkg::MODE_ACK,     5'd0,  1'b1, srarq_pkg::KIND_BAD_ID,  5'd0},
    '{srarq_pkg::MODE_NACK,    5'd11, 1'b1, srarq_pkg::KIND_BAD_ID,  5'd11},
    '{srarq_pkg::MODE_ACK,     5'd31, 1'b1, srarq_pkg::KIND_BAD_ID,  5'd31},
    '{srarq_pkg::MODE_TICK,    5'd0,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_ACK,     5'd5,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_NACK,    5'd2,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_ACK,     5'd2,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_ACK,     5'd1,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_NACK,    5'd1,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_NACK,    5'd9,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_TICK,    5'd21, 1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_TICK,    5'd10, 1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_TICK,    5'd0,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_TICK,    5'd31, 1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_TICK,    5'd0,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_INVALID, 5'd16, 1'b1, srarq_pkg::KIND_INVALID, 5'd0},
    '{srarq_pkg::MODE_ACK,     5'd3,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_NACK,    5'd10, 1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_ACK,     5'd10, 1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_TICK,    5'd0,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_NACK,    5'd4,  1'b0, srarq_pkg::KIND_FIRST,   5'd0},
    '{srarq_pkg::MODE_INVALID, 5'd31, 1'b1, srarq_pkg::KIND_INVALID, 5'd0}
  };

  selective_repeat_arq_sender_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned total_used();
    int unsigned t;
    t = 32'(reg_total);
    if (t < 1) t = 1;
    if (t > MAX_PKT) t = MAX_PKT;
    return t;
  endfunction

  function automatic int unsigned window_used();
    int unsigned w;
    w = 32'(reg_window);
    if (w < 1) w = 1;
    if (w > MAX_WIN) w = MAX_WIN;
    return w;
  endfunction

  function automatic int unsigned timeout_used();
    return (reg_timeout == 8'd0) ? 1 : 32'(reg_timeout);
  endfunction

  function automatic void add_cmd(input srarq_pkg::kind_t k, input logic [4:0] id);
    if (step_cmds.size() < srarq_pkg::RESULT_CAP) step_cmds.push_back('{k, id, 1'b0});
  endfunction

  // send commands caused by one request, in issue order
  task automatic window_step(input srarq_pkg::mode_t m, input logic [4:0] id);
    int unsigned total, lim, i, k;
    sr_result_t c;
    total = total_used();
    step_cmds.delete();
    if (m == srarq_pkg::MODE_INVALID) begin
      add_cmd(srarq_pkg::KIND_INVALID, 5'd0);
    end else if (m != srarq_pkg::MODE_TICK && (id == 5'd0 || id > total)) begin
      add_cmd(srarq_pkg::KIND_BAD_ID, id);
    end else if (!xfer_done) begin
      if (m == srarq_pkg::MODE_TICK) begin
        for (i = base_idx; i < unsent_idx && i < MAX_PKT; i++) begin
          if (pkt_launched[i] && !pkt_acked[i]) begin
            if (pkt_timer[i] <= 1) begin
              add_cmd(srarq_pkg::KIND_TIMEOUT, 5'(i + 1));
              pkt_timer[i] = timeout_used();
            end else begin
              pkt_timer[i] = pkt_timer[i] - 1;
            end
          end
        end
      end else if (m == srarq_pkg::MODE_NACK) begin
        k = 32'(id) - 1;
        if (pkt_launched[k] && !pkt_acked[k]) begin
          add_cmd(srarq_pkg::KIND_NACK, id);
          pkt_timer[k] = timeout_used();
        end
      end else begin
        k = 32'(id) - 1;
        if (pkt_launched[k]) begin
          pkt_acked[k] = 1'b1;
          while (base_idx < total && base_idx < MAX_PKT && pkt_acked[base_idx])
            base_idx++;
        end
      end
      lim = base_idx + window_used();
      while (step_cmds.size() < srarq_pkg::RESULT_CAP && unsent_idx < lim &&
             unsent_idx < total) begin
        pkt_launched[unsent_idx] = 1'b1;
        pkt_timer[unsent_idx] = timeout_used();
        add_cmd(srarq_pkg::KIND_FIRST, 5'(unsent_idx + 1));
        unsent_idx++;
      end
      if (base_idx >= total && step_cmds.size() < srarq_pkg::RESULT_CAP) begin
        xfer_done = 1'b1;
        add_cmd(srarq_pkg::KIND_DONE, 5'd0);
      end
    end
    if (step_cmds.size() != 0) begin
      c = step_cmds.pop_back();
      c.last = 1'b1;
      step_cmds.push_back(c);
    end
  endtask

  function automatic logic [4:0] live_pkt();
    logic [4:0] ids [$];
    int unsigned i;
    for (i = base_idx; i < unsent_idx && i < MAX_PKT; i++)
      if (pkt_launched[i] && !pkt_acked[i]) ids.push_back(5'(i + 1));
    if (ids.size() == 0) return 5'd0;
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // ack id that cannot move the window: zero, out of range, already acked or never sent
  function automatic logic [4:0] stale_ack_id();
    int unsigned t;
    t = total_used();
    case ($urandom_range(0, 3))
      0: return 5'd0;
      1: return 5'($urandom_range(t + 1, 31));
      2: return (base_idx > 0) ? 5'($urandom_range(1, base_idx)) : 5'd0;
      default: return (unsent_idx < t) ? 5'($urandom_range(unsent_idx + 1, t)) : 5'd31;
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    err_cnt++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      srarq_pkg::CFG_PACKET_TOTAL:  reg_total = val[4:0];
      srarq_pkg::CFG_WINDOW_WIDTH:  reg_window = val[3:0];
      srarq_pkg::CFG_TIMEOUT_TICKS: reg_timeout = val;
      default: ;
    endcase
  endtask

  task automatic push_req(input srarq_pkg::mode_t m, input logic [4:0] id,
                          input logic typed, input srarq_pkg::kind_t tk,
                          input logic [4:0] tid);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= m;
    in_tdata <= {3'b000, id};
    do @(posedge clk); while (in_tready !== 1'b1);
    window_step(m, id);
    if (typed) begin
      step_cmds.delete();
      step_cmds.push_back('{tk, tid, 1'b1});
    end
    foreach (step_cmds[j]) due_cmds.push_back(step_cmds[j]);
  endtask

  // wait for every due command, then let a request that sends nothing finish
  task automatic settle();
    int k;
    in_tvalid <= 1'b0;
    burst_left = 0;
    for (k = 0; k < DRAIN_MAX && due_cmds.size() != 0; k++) @(posedge clk);
    if (due_cmds.size() != 0) begin
      flag_mismatch($sformatf("%0d send commands never arrived", due_cmds.size()));
      due_cmds.delete();
    end
    repeat (IDLE_HOLD) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(RX_OPEN, RX_CADENCE);
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= ((cyc % 5) < 2);
    endcase
  end

  always @(posedge clk) begin
    sr_result_t e;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (due_cmds.size() == 0) begin
        flag_mismatch($sformatf("unexpected command kind %0d id %0d last %0b",
                                out_tuser, out_tdata, out_tlast));
      end else begin
        e = due_cmds.pop_front();
        if (out_tuser !== e.kind || out_tdata !== {3'b000, e.pid} || out_tlast !== e.last)
          flag_mismatch($sformatf("got kind %0d id %0d last %0b, want kind %0d id %0d last %0b",
                                  out_tuser, out_tdata, out_tlast, e.kind, e.pid, e.last));
      end
    end
  end

  initial begin
    srarq_pkg::mode_t m;
    logic [4:0]       id;
    logic [7:0]       v_total, v_win, v_tmo;
    int               ph, it, n_items, r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      push_req(dir_tab[i].m, dir_tab[i].id, dir_tab[i].typed, dir_tab[i].k, dir_tab[i].kid);

    for (ph = 0; ph < N_PHASE; ph++) begin
      settle();
      case (ph)
        0:       begin v_total = 8'd31; v_win = 8'd8;  v_tmo = 8'd1;   end
        1:       begin v_total = 8'd16; v_win = 8'd1;  v_tmo = 8'd255; end
        2:       begin v_total = 8'd16; v_win = 8'd8;  v_tmo = 8'd0;   end
        3:       begin v_total = 8'd16; v_win = 8'd15; v_tmo = 8'd3;   end
        4:       begin v_total = 8'd16; v_win = 8'd4;  v_tmo = 8'd2;   end
        5:       begin v_total = 8'd16; v_win = 8'd2;  v_tmo = 8'd7;   end
        default: begin v_total = 8'd0;  v_win = 8'd0;  v_tmo = 8'd255; end
      endcase
      write_reg(srarq_pkg::CFG_PACKET_TOTAL, v_total);
      write_reg(srarq_pkg::CFG_WINDOW_WIDTH, v_win);
      write_reg(srarq_pkg::CFG_TIMEOUT_TICKS, v_tmo);
      cfg_we <= 1'b0;
      n_items = (ph == N_PHASE - 1) ? 20 : 72;
      for (it = 0; it < n_items; it++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          m = srarq_pkg::MODE_TICK;
          id = 5'($urandom_range(0, 31));
        end else if (r < 65) begin
          m = srarq_pkg::MODE_NACK;
          id = live_pkt();
          if (id == 5'd0 || $urandom_range(0, 3) == 0) id = 5'($urandom_range(0, 31));
        end else if (r < 85) begin
          // live acks are rationed so the transfer completes near the end
          m = srarq_pkg::MODE_ACK;
          id = live_pkt();
          if (id != 5'd0 && (ph >= 5 || acks_granted < 3 * (ph + 1))) acks_granted++;
          else id = stale_ack_id();
        end else if (r < 95) begin
          m = srarq_pkg::MODE_INVALID;
          id = 5'($urandom_range(0, 31));
        end else begin
          m = srarq_pkg::mode_t'($urandom_range(0, 3));
          id = 5'($urandom_range(0, 31));
        end
        push_req(m, id, 1'b0, srarq_pkg::KIND_FIRST, 5'd0);
      end
    end
    settle();

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
